FILE: hw/rtl/tss_pkg.sv
// Shared types and constants for the traffic signal sequencer.
// No dependencies; the modules and the testbench import this package.
package tss_pkg;

  // Fixed interval lengths, in seconds
  localparam int unsigned NS_WALK_SECS = 6;
  localparam int unsigned EW_WALK_SECS = 6;
  localparam int unsigned YELLOW_SECS  = 3;

  // Configuration bank geometry
  localparam int unsigned NUM_CFG   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SECS_W    = 8;
  localparam int unsigned COUNT_W   = 4;

  typedef logic [SECS_W-1:0] secs_t;
  typedef secs_t [NUM_CFG-1:0] cfg_bank_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DAY_NS_GREEN   = 3'd0,
    CFG_DAY_EW_GREEN   = 3'd1,
    CFG_DAY_NS_LEFT    = 3'd2,
    CFG_DAY_EW_LEFT    = 3'd3,
    CFG_NIGHT_NS_GREEN = 3'd4,
    CFG_NIGHT_EW_GREEN = 3'd5,
    CFG_NIGHT_NS_LEFT  = 3'd6,
    CFG_NIGHT_EW_LEFT  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LAMP_OFF    = 2'd0,
    LAMP_RED    = 2'd1,
    LAMP_GREEN  = 2'd2,
    LAMP_YELLOW = 2'd3
  } lamp_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_NS_WALK    = 4'd1,
    PH_NS_GREEN   = 4'd2,
    PH_NS_YELLOW  = 4'd3,
    PH_EWL_GREEN  = 4'd4,
    PH_EWL_YELLOW = 4'd5,
    PH_EW_WALK    = 4'd6,
    PH_EW_GREEN   = 4'd7,
    PH_EW_YELLOW  = 4'd8,
    PH_NSL_GREEN  = 4'd9,
    PH_NSL_YELLOW = 4'd10
  } phase_t;

  // Switch levels of one tick
  typedef struct packed {
    logic ns_walk_request;
    logic ew_walk_request;
    logic ns_turn_request;
    logic ew_turn_request;
    logic daylight;
  } tick_req_t;

  // Lamp state of one second
  typedef struct packed {
    lamp_t              ns_lamp;
    lamp_t              ns_turn_lamp;
    lamp_t              ew_lamp;
    lamp_t              ew_turn_lamp;
    logic               walk_active;
    logic               walk_side;
    logic [COUNT_W-1:0] walk_countdown;
    logic               night_active;
    logic               cycle_end;
  } lamp_res_t;

  // Reset value of each configuration register
  function automatic secs_t cfg_reset_val(input cfg_idx_t idx);
    secs_t v;
    case (idx)
      CFG_DAY_NS_LEFT, CFG_DAY_EW_LEFT,
      CFG_NIGHT_NS_LEFT, CFG_NIGHT_EW_LEFT: v = secs_t'(6);
      default:                              v = secs_t'(8);
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/tss_tick_if.sv
// Tick channel: valid/ready handshake plus the switch levels of one second.
// Standalone interface, no package dependency.
interface tss_tick_if;
  logic valid;
  logic ready;
  logic ns_walk_request;
  logic ew_walk_request;
  logic ns_turn_request;
  logic ew_turn_request;
  logic daylight;

  modport source (
    output valid, ns_walk_request, ew_walk_request, ns_turn_request,
           ew_turn_request, daylight,
    input  ready
  );

  modport sink (
    input  valid, ns_walk_request, ew_walk_request, ns_turn_request,
           ew_turn_request, daylight,
    output ready
  );
endinterface

FILE: hw/rtl/tss_lamp_if.sv
// Lamp channel: valid/ready handshake plus the lamp state of one second.
// Standalone interface, no package dependency.
interface tss_lamp_if;
  logic       valid;
  logic       ready;
  logic [1:0] ns_lamp;
  logic [1:0] ns_turn_lamp;
  logic [1:0] ew_lamp;
  logic [1:0] ew_turn_lamp;
  logic       walk_active;
  logic       walk_side;
  logic [3:0] walk_countdown;
  logic       night_active;
  logic       cycle_end;

  modport source (
    output valid, ns_lamp, ns_turn_lamp, ew_lamp, ew_turn_lamp, walk_active,
           walk_side, walk_countdown, night_active, cycle_end,
    input  ready
  );

  modport sink (
    input  valid, ns_lamp, ns_turn_lamp, ew_lamp, ew_turn_lamp, walk_active,
           walk_side, walk_countdown, night_active, cycle_end,
    output ready
  );
endinterface

FILE: hw/rtl/traffic_signal_sequencer_unit.sv
// Top level of the four-approach traffic signal sequencer.
// Depends on tss_pkg, tss_tick_if, tss_lamp_if, tss_cfg_regs, tss_phase_seq, tss_out_buf.
//
//   channel   direction  beat contents
//   tick      in         switch levels of one second
//   lamps     out        lamp colours, walk status, cycle end of that second
//   cfg_*     in         write of one duration register
//
// One tick beat per clock while tick.ready is high; lamp beats are buffered in order.
// The phase machine and seconds counter update in the accepting cycle.
// A two-entry output buffer keeps ticks flowing while one lamp beat waits;
// tick.ready drops only when both entries are full.
// Synchronous reset puts the sequencer in its all-red idle second.
module traffic_signal_sequencer_unit
  import tss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  tss_tick_if.sink             tick,
  tss_lamp_if.source           lamps,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SECS_W-1:0]    cfg_data
);

  cfg_bank_t bank;
  tick_req_t req;
  lamp_res_t res;
  logic      space;
  logic      accept;

  assign tick.ready = space;
  assign accept     = tick.valid && space;

  assign req.ns_walk_request = tick.ns_walk_request;
  assign req.ew_walk_request = tick.ew_walk_request;
  assign req.ns_turn_request = tick.ns_turn_request;
  assign req.ew_turn_request = tick.ew_turn_request;
  assign req.daylight        = tick.daylight;

  tss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bank      (bank)
  );

  tss_phase_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .bank   (bank),
    .res    (res)
  );

  tss_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .space     (space),
    .lamps     (lamps)
  );

endmodule

FILE: hw/rtl/tss_cfg_regs.sv
// Bank of eight green/left-turn duration registers with a plain write port.
// Depends on tss_pkg.
module tss_cfg_regs
  import tss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SECS_W-1:0]    cfg_data,
  output cfg_bank_t            bank
);

  // Register bank, loaded with defaults on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        bank[i] <= cfg_reset_val(cfg_idx_t'(i));
      end
    end else if (cfg_we) begin
      bank[cfg_index] <= cfg_data;
    end
  end

endmodule

FILE: hw/rtl/tss_phase_seq.sv
// Phase machine and seconds counter: one tick in, one lamp result out.
// Depends on tss_pkg; durations come from tss_cfg_regs.
module tss_phase_seq
  import tss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  tick_req_t req,
  input  cfg_bank_t bank,
  output lamp_res_t res
);

  phase_t phase, phase_next;
  secs_t  seconds_left, seconds_left_next;
  logic   night_latched, night_latched_next;

  logic   last;
  logic   cycle_done;
  secs_t  len;
  secs_t  secs_less1;

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      seconds_left  <= '0;
      night_latched <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      seconds_left  <= seconds_left_next;
      night_latched <= night_latched_next;
    end
  end

  assign last       = (seconds_left <= secs_t'(1));
  assign secs_less1 = seconds_left - secs_t'(1);

  // Lamp decode of the current phase
  always_comb begin
    res                = '0;
    res.ns_lamp        = LAMP_RED;
    res.ns_turn_lamp   = LAMP_RED;
    res.ew_lamp        = LAMP_RED;
    res.ew_turn_lamp   = LAMP_RED;
    res.night_active   = night_latched;
    case (phase)
      PH_NS_WALK: begin
        res.walk_active = 1'b1;
        res.ns_lamp     = LAMP_GREEN;
      end
      PH_NS_GREEN:   res.ns_lamp      = LAMP_GREEN;
      PH_NS_YELLOW:  res.ns_lamp      = LAMP_YELLOW;
      PH_EWL_GREEN:  res.ew_turn_lamp = LAMP_GREEN;
      PH_EWL_YELLOW: res.ew_turn_lamp = LAMP_YELLOW;
      PH_EW_WALK: begin
        res.walk_active = 1'b1;
        res.walk_side   = 1'b1;
        res.ew_lamp     = LAMP_GREEN;
      end
      PH_EW_GREEN:   res.ew_lamp      = LAMP_GREEN;
      PH_EW_YELLOW:  res.ew_lamp      = LAMP_YELLOW;
      PH_NSL_GREEN:  res.ns_turn_lamp = LAMP_GREEN;
      PH_NSL_YELLOW: res.ns_turn_lamp = LAMP_YELLOW;
      default: ;
    endcase
    if (res.walk_active && !last) begin
      res.walk_countdown = secs_less1[COUNT_W-1:0];
    end
    res.cycle_end = cycle_done;
  end

  // Next phase and its length on the last second of a phase
  always_comb begin
    phase_next         = phase;
    night_latched_next = night_latched;
    len                = secs_t'(1);
    cycle_done         = 1'b0;
    case (phase)
      PH_NS_WALK: begin
        phase_next = PH_NS_GREEN;
        len = night_latched ? bank[CFG_NIGHT_NS_GREEN] : bank[CFG_DAY_NS_GREEN];
      end
      PH_NS_GREEN: begin
        phase_next = PH_NS_YELLOW;
        len        = secs_t'(YELLOW_SECS);
      end
      PH_NS_YELLOW, PH_EWL_YELLOW: begin
        if (phase == PH_NS_YELLOW && req.ew_turn_request) begin
          phase_next = PH_EWL_GREEN;
          len = night_latched ? bank[CFG_NIGHT_EW_LEFT] : bank[CFG_DAY_EW_LEFT];
        end else if (!night_latched && req.ew_walk_request) begin
          phase_next = PH_EW_WALK;
          len        = secs_t'(EW_WALK_SECS);
        end else begin
          phase_next = PH_EW_GREEN;
          len = night_latched ? bank[CFG_NIGHT_EW_GREEN] : bank[CFG_DAY_EW_GREEN];
        end
      end
      PH_EWL_GREEN, PH_EW_GREEN, PH_NSL_GREEN: begin
        phase_next = (phase == PH_EWL_GREEN) ? PH_EWL_YELLOW :
                     (phase == PH_EW_GREEN)  ? PH_EW_YELLOW  : PH_NSL_YELLOW;
        len        = secs_t'(YELLOW_SECS);
      end
      PH_EW_WALK: begin
        phase_next = PH_EW_GREEN;
        len = night_latched ? bank[CFG_NIGHT_EW_GREEN] : bank[CFG_DAY_EW_GREEN];
      end
      default: begin
        // idle, yellow ends of the cycle, and unused codes
        if (phase == PH_EW_YELLOW && req.ns_turn_request) begin
          phase_next = PH_NSL_GREEN;
          len = night_latched ? bank[CFG_NIGHT_NS_LEFT] : bank[CFG_DAY_NS_LEFT];
        end else begin
          cycle_done         = (phase == PH_EW_YELLOW) || (phase == PH_NSL_YELLOW);
          night_latched_next = !req.daylight;
          if (req.daylight && req.ns_walk_request) begin
            phase_next = PH_NS_WALK;
            len        = secs_t'(NS_WALK_SECS);
          end else begin
            phase_next = PH_NS_GREEN;
            len = req.daylight ? bank[CFG_DAY_NS_GREEN] : bank[CFG_NIGHT_NS_GREEN];
          end
        end
      end
    endcase

    // mid-phase seconds just count down
    if (!last) begin
      phase_next         = phase;
      night_latched_next = night_latched;
      cycle_done         = 1'b0;
      seconds_left_next  = secs_less1;
    end else begin
      seconds_left_next  = (len == '0) ? secs_t'(1) : len;
    end
  end

endmodule

FILE: hw/rtl/tss_out_buf.sv
// Two-entry result buffer between the phase machine and the lamp channel.
// Depends on tss_pkg and tss_lamp_if.
module tss_out_buf
  import tss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lamp_res_t push_data,
  output logic      space,
  tss_lamp_if.source lamps
);

  lamp_res_t head, tail;
  logic      head_valid, tail_valid;
  logic      pop;

  assign pop   = head_valid && lamps.ready;
  assign space = !tail_valid;

  // Occupancy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (head_valid) tail_valid <= 1'b1;
          else            head_valid <= 1'b1;
        end
        2'b01: begin
          if (tail_valid) tail_valid <= 1'b0;
          else            head_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Beat payload storage
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (head_valid) tail <= push_data;
        else            head <= push_data;
      end
      2'b01: begin
        if (tail_valid) head <= tail;
      end
      2'b11: begin
        if (tail_valid) begin
          head <= tail;
          tail <= push_data;
        end else begin
          head <= push_data;
        end
      end
      default: ;
    endcase
  end

  assign lamps.valid          = head_valid;
  assign lamps.ns_lamp        = head.ns_lamp;
  assign lamps.ns_turn_lamp   = head.ns_turn_lamp;
  assign lamps.ew_lamp        = head.ew_lamp;
  assign lamps.ew_turn_lamp   = head.ew_turn_lamp;
  assign lamps.walk_active    = head.walk_active;
  assign lamps.walk_side      = head.walk_side;
  assign lamps.walk_countdown = head.walk_countdown;
  assign lamps.night_active   = head.night_active;
  assign lamps.cycle_end      = head.cycle_end;

endmodule

FILE: tb/traffic_signal_sequencer_unit_test.sv
// Testbench for traffic_signal_sequencer_unit: directed and random tick beats,
// with every lamp beat checked against a phase predictor held in a scoreboard.
// Depends on tss_pkg, tss_tick_if, tss_lamp_if and the sequencer RTL.
module traffic_signal_sequencer_unit_test;
  import tss_pkg::*;

  localparam int unsigned HOLD_CYCLES = 48;
  localparam int unsigned RUN_LIMIT   = 200000;

  typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Phase predictor plus the queue of lamp beats still owed by the DUT
  class lamp_scoreboard;
    cfg_bank_t   durations;
    phase_t      phase;
    secs_t       secs_left;
    logic        night;
    lamp_res_t   lamp_q[$];
    int unsigned mismatches, beats, cycles_done, walk_secs, night_secs;

    function new();
      durations[CFG_DAY_NS_GREEN]   = 8;
      durations[CFG_DAY_EW_GREEN]   = 8;
      durations[CFG_DAY_NS_LEFT]    = 6;
      durations[CFG_DAY_EW_LEFT]    = 6;
      durations[CFG_NIGHT_NS_GREEN] = 8;
      durations[CFG_NIGHT_EW_GREEN] = 8;
      durations[CFG_NIGHT_NS_LEFT]  = 6;
      durations[CFG_NIGHT_EW_LEFT]  = 6;
      phase = PH_IDLE;
      secs_left = '0;
      night = 1'b0;
      mismatches = 0;
      beats = 0;
      cycles_done = 0;
      walk_secs = 0;
      night_secs = 0;
    endfunction

    function void set_duration(cfg_idx_t idx, secs_t val);
      durations[idx] = val;
    endfunction

    function int unsigned pending();
      return lamp_q.size();
    endfunction

    // A length of zero runs as one second
    function void enter(phase_t p, int unsigned len);
      secs_t l;
      l = secs_t'(len);
      phase = p;
      secs_left = (l == 0) ? secs_t'(1) : l;
    endfunction

    function secs_t green_of(cfg_idx_t day_reg, cfg_idx_t night_reg);
      return night ? durations[night_reg] : durations[day_reg];
    endfunction

    // Mode is latched here; walk requests only count in day mode
    function void start_cycle(tick_req_t t);
      night = !t.daylight;
      if (!night && t.ns_walk_request)
        enter(PH_NS_WALK, NS_WALK_SECS);
      else
        enter(PH_NS_GREEN, green_of(CFG_DAY_NS_GREEN, CFG_NIGHT_NS_GREEN));
    endfunction

    function void start_ew(tick_req_t t);
      if (!night && t.ew_walk_request)
        enter(PH_EW_WALK, EW_WALK_SECS);
      else
        enter(PH_EW_GREEN, green_of(CFG_DAY_EW_GREEN, CFG_NIGHT_EW_GREEN));
    endfunction

    // Picks the next phase on the last second; returns 1 when a cycle ends
    function bit advance(tick_req_t t);
      bit done;
      done = 1'b0;
      case (phase)
        PH_NS_WALK:    enter(PH_NS_GREEN, green_of(CFG_DAY_NS_GREEN, CFG_NIGHT_NS_GREEN));
        PH_NS_GREEN:   enter(PH_NS_YELLOW, YELLOW_SECS);
        PH_NS_YELLOW: begin
          if (t.ew_turn_request)
            enter(PH_EWL_GREEN, green_of(CFG_DAY_EW_LEFT, CFG_NIGHT_EW_LEFT));
          else
            start_ew(t);
        end
        PH_EWL_GREEN:  enter(PH_EWL_YELLOW, YELLOW_SECS);
        PH_EWL_YELLOW: start_ew(t);
        PH_EW_WALK:    enter(PH_EW_GREEN, green_of(CFG_DAY_EW_GREEN, CFG_NIGHT_EW_GREEN));
        PH_EW_GREEN:   enter(PH_EW_YELLOW, YELLOW_SECS);
        PH_EW_YELLOW: begin
          if (t.ns_turn_request) begin
            enter(PH_NSL_GREEN, green_of(CFG_DAY_NS_LEFT, CFG_NIGHT_NS_LEFT));
          end else begin
            start_cycle(t);
            done = 1'b1;
          end
        end
        PH_NSL_GREEN:  enter(PH_NSL_YELLOW, YELLOW_SECS);
        PH_NSL_YELLOW: begin
          start_cycle(t);
          done = 1'b1;
        end
        default:       start_cycle(t);
      endcase
      return done;
    endfunction

    // Works out the lamp beat of one accepted tick
    function void note_tick(tick_req_t t);
      lamp_res_t r;
      secs_t     remain;
      bit        last;
      r = '0;
      r.ns_lamp      = LAMP_RED;
      r.ns_turn_lamp = LAMP_RED;
      r.ew_lamp      = LAMP_RED;
      r.ew_turn_lamp = LAMP_RED;
      r.night_active = night;
      last = (secs_left <= 1);
      case (phase)
        PH_NS_WALK: begin
          r.ns_lamp = LAMP_GREEN;
          r.walk_active = 1'b1;
        end
        PH_NS_GREEN:   r.ns_lamp = LAMP_GREEN;
        PH_NS_YELLOW:  r.ns_lamp = LAMP_YELLOW;
        PH_EWL_GREEN:  r.ew_turn_lamp = LAMP_GREEN;
        PH_EWL_YELLOW: r.ew_turn_lamp = LAMP_YELLOW;
        PH_EW_WALK: begin
          r.ew_lamp = LAMP_GREEN;
          r.walk_active = 1'b1;
          r.walk_side = 1'b1;
        end
        PH_EW_GREEN:   r.ew_lamp = LAMP_GREEN;
        PH_EW_YELLOW:  r.ew_lamp = LAMP_YELLOW;
        PH_NSL_GREEN:  r.ns_turn_lamp = LAMP_GREEN;
        PH_NSL_YELLOW: r.ns_turn_lamp = LAMP_YELLOW;
        default: ;
      endcase
      if (r.walk_active && !last) begin
        remain = secs_left - 1'b1;
        r.walk_countdown = remain[COUNT_W-1:0];
      end
      if (last)
        r.cycle_end = advance(t);
      else
        secs_left = secs_left - 1'b1;
      lamp_q.push_back(r);
    endfunction

    function void show_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got)
        $display("%0t  %s: expected %0d, got %0d", $time, name, want, got);
    endfunction

    // Matches one lamp beat from the DUT against the oldest expectation
    function void check_lamps(lamp_res_t got);
      lamp_res_t want;
      beats++;
      cycles_done += got.cycle_end;
      walk_secs   += got.walk_active;
      night_secs  += got.night_active;
      if (lamp_q.size() == 0) begin
        mismatches++;
        $display("%0t  lamp beat with no tick waiting: expected none, got %h", $time, got);
      end else begin
        want = lamp_q.pop_front();
        if (want !== got) begin
          mismatches++;
          show_field("ns_lamp", want.ns_lamp, got.ns_lamp);
          show_field("ns_turn_lamp", want.ns_turn_lamp, got.ns_turn_lamp);
          show_field("ew_lamp", want.ew_lamp, got.ew_lamp);
          show_field("ew_turn_lamp", want.ew_turn_lamp, got.ew_turn_lamp);
          show_field("walk_active", want.walk_active, got.walk_active);
          show_field("walk_side", want.walk_side, got.walk_side);
          show_field("walk_countdown", want.walk_countdown, got.walk_countdown);
          show_field("night_active", want.night_active, got.night_active);
          show_field("cycle_end", want.cycle_end, got.cycle_end);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SECS_W-1:0]    cfg_data;

  tss_tick_if tick_ch ();
  tss_lamp_if lamp_ch ();

  lamp_scoreboard lamp_sb = new();

  int unsigned hold_asks = 0;
  int unsigned hold_taken = 0;
  int unsigned ticks_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  traffic_signal_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .lamps     (lamp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receiver stall pattern; a requested hold-off overrides it
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  always @(negedge clk) begin
    if (hold_taken < hold_asks && hold_left == 0) begin
      hold_taken++;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(5, 60);
    end
    mode_left--;
    if (hold_left != 0) begin
      hold_left--;
      lamp_ch.ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:  lamp_ch.ready = 1'b1;
        RX_LIGHT: lamp_ch.ready = ($urandom_range(0, 3) != 0);
        RX_HEAVY: lamp_ch.ready = ($urandom_range(0, 9) < 4);
        default:  lamp_ch.ready = ((mode_left % 3) == 0);
      endcase
    end
  end

  // Lamp beat monitor
  always @(posedge clk) begin
    lamp_res_t got;
    if (!rst && lamp_ch.valid && lamp_ch.ready) begin
      got.ns_lamp        = lamp_t'(lamp_ch.ns_lamp);
      got.ns_turn_lamp   = lamp_t'(lamp_ch.ns_turn_lamp);
      got.ew_lamp        = lamp_t'(lamp_ch.ew_lamp);
      got.ew_turn_lamp   = lamp_t'(lamp_ch.ew_turn_lamp);
      got.walk_active    = lamp_ch.walk_active;
      got.walk_side      = lamp_ch.walk_side;
      got.walk_countdown = lamp_ch.walk_countdown;
      got.night_active   = lamp_ch.night_active;
      got.cycle_end      = lamp_ch.cycle_end;
      lamp_sb.check_lamps(got);
    end
  end

  function automatic tick_req_t random_tick(int unsigned day_pct);
    tick_req_t t;
    t.ns_walk_request = $urandom_range(0, 1);
    t.ew_walk_request = $urandom_range(0, 1);
    t.ns_turn_request = $urandom_range(0, 1);
    t.ew_turn_request = $urandom_range(0, 1);
    t.daylight        = ($urandom_range(0, 99) < day_pct);
    return t;
  endfunction

  // Offers one tick beat and holds it until accepted; valid stays high
  task automatic send_tick(tick_req_t t);
    @(negedge clk);
    tick_ch.valid           = 1'b1;
    tick_ch.ns_walk_request = t.ns_walk_request;
    tick_ch.ew_walk_request = t.ew_walk_request;
    tick_ch.ns_turn_request = t.ns_turn_request;
    tick_ch.ew_turn_request = t.ew_turn_request;
    tick_ch.daylight        = t.daylight;
    do begin
      @(posedge clk);
    end while (tick_ch.ready !== 1'b1);
    lamp_sb.note_tick(t);
    ticks_sent++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    @(negedge clk);
    tick_ch.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_sender(0);
    while (lamp_sb.pending() != 0) @(posedge clk);
  endtask

  // Random ticks in bursts with random gaps; gap_pct 0 gives a gapless stretch
  task automatic run_ticks(int unsigned count, int unsigned day_pct, int unsigned gap_pct);
    int unsigned burst;
    while (count != 0) begin
      burst = $urandom_range(1, 24);
      if (burst > count)
        burst = count;
      count -= burst;
      repeat (burst) send_tick(random_tick(day_pct));
      if ($urandom_range(0, 99) < gap_pct)
        idle_sender($urandom_range(0, 6));
    end
    idle_sender(0);
  endtask

  // Writes all eight duration registers; only called with the block drained
  task automatic load_durations(cfg_bank_t vals);
    int i;
    for (i = 0; i < NUM_CFG; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = cfg_idx_t'(i);
      cfg_data  = vals[i];
      lamp_sb.set_duration(cfg_idx_t'(i), vals[i]);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    #RUN_LIMIT;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    cfg_bank_t bank;
    tick_req_t t;
    int        i;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_DAY_NS_GREEN;
    cfg_data                = '0;
    tick_ch.valid           = 1'b0;
    tick_ch.ns_walk_request = 1'b0;
    tick_ch.ew_walk_request = 1'b0;
    tick_ch.ns_turn_request = 1'b0;
    tick_ch.ew_turn_request = 1'b0;
    tick_ch.daylight        = 1'b0;
    lamp_ch.ready           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero durations run as one second, keeping the directed cycles short
    bank = '0;
    load_durations(bank);

    // Night cycle with every request high: walks ignored, both turn lanes run
    t = '1;
    t.daylight = 1'b0;
    repeat (16) send_tick(t);
    // Day cycle with no requests, then an all-low tick
    t = '0;
    t.daylight = 1'b1;
    repeat (8) send_tick(t);
    send_tick('0);

    // Shortest phases: every register at zero or one second
    wait_drained();
    for (i = 0; i < NUM_CFG; i++)
      bank[i] = secs_t'($urandom_range(0, 1));
    load_durations(bank);
    run_ticks(80, 60, 75);

    // Mid-range durations, then a receiver hold-off while ticks keep coming
    wait_drained();
    for (i = 0; i < NUM_CFG; i++)
      bank[i] = secs_t'($urandom_range(1, 12));
    load_durations(bank);
    run_ticks(50, 75, 75);
    hold_asks++;
    run_ticks(40, 75, 0);
    wait_drained();
    run_ticks(30, 75, 50);

    // Longest greens and turns, partly without sender gaps
    wait_drained();
    bank = '1;
    load_durations(bank);
    run_ticks(120, 50, 0);
    run_ticks(150, 50, 60);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Ran %0d ticks, %0d lamp beats: %0d full cycles, %0d walk and %0d night seconds.",
             ticks_sent, lamp_sb.beats, lamp_sb.cycles_done, lamp_sb.walk_secs,
             lamp_sb.night_secs);
    $display("Durations covered zero, one, mid-range and 255 seconds; one %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (lamp_sb.mismatches == 0 && lamp_sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
